// ----- hw/rtl/rgb_to_hsl_converter_assert.svh -----
// Assertion macros shared by the RGB to HSL converter RTL.
`ifndef RGB_TO_HSL_CONVERTER_ASSERT_SVH
`define RGB_TO_HSL_CONVERTER_ASSERT_SVH
`ifndef SYNTH
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsl_converter: same-cycle check failed");
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hsl_converter: next-cycle check failed");
`else
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/rhc_pkg.sv -----
// Shared constants of the RGB to HSL converter.
package rhc_pkg;
   localparam int CH_W = 8;
   localparam int OUT_W = 13;
   localparam int SECTOR_W = 11;
   localparam int HUE_FRAC_BITS_DEFAULT = 4;
   localparam int LEVEL_BITS_DEFAULT = 12;
   localparam int LIGHT_DEN = 510;
   localparam int DEGREES_PER_SECTOR = 60;
endpackage

// ----- hw/rtl/rhc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module rhc_div #(
   parameter int QW = 13,
   parameter int DW = 8
) (
   input  logic               clock,
   input  logic [QW+DW-1:0]   num,
   input  logic [DW-1:0]      den,
   output logic [QW-1:0]      quo
);
   // The caller guarantees num < den * 2^QW, so the upper bits start below den.
   logic [DW-1:0] rem_ff [QW];
   logic [DW-1:0] rem_in [QW];
   logic [DW-1:0] den_ff [QW];
   logic [DW-1:0] den_in [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] low_in [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [QW-1:0] quo_in [QW];

   for (genvar i = 0; i < QW; i++) begin : g_step
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [QW-1:0] low_src;
      logic [QW-1:0] quo_src;
      logic [DW:0]   trial;
      logic          fits;

      if (i == 0) begin : g_first
         assign rem_src = num[QW+DW-1:QW];
         assign den_src = den;
         assign low_src = num[QW-1:0];
         assign quo_src = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_src = den_ff[i-1];
         assign low_src = low_ff[i-1];
         assign quo_src = quo_ff[i-1];
      end

      always_comb begin
         trial = {rem_src, low_src[QW-1-i]};
         fits = trial >= {1'b0, den_src};
         rem_in[i] = fits ? DW'(trial - {1'b0, den_src}) : DW'(trial);
         den_in[i] = den_src;
         low_in[i] = low_src;
         quo_in[i] = quo_src;
         quo_in[i][QW-1-i] = fits;
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in[i];
         den_ff[i] <= den_in[i];
         low_ff[i] <= low_in[i];
         quo_ff[i] <= quo_in[i];
      end
   end

   assign quo = quo_ff[QW-1];
endmodule

// ----- hw/rtl/rgb_to_hsl_converter.sv -----
// Top level of the pipelined RGB to HSL pixel converter.
//
//   Channel   Ports                                      Handshake
//   request   req_red, req_green, req_blue               start high, busy low
//   response  rsp_hue, rsp_saturation, rsp_lightness     rsp_valid strobe, one cycle
//
// One pixel beat is taken in every clock cycle while busy is low; each beat passes through
// an input register, a sector stage, a numerator stage, QW divider stages of one quotient
// bit each and an output register. Lightness uses a reciprocal multiply by 1/510 and a
// delay line of the same QW stages.
// Reset is synchronous and clears only the valid bits; busy is high while reset is.
// The receiver cannot stall, so the pipeline never stops and busy stays low otherwise.
`include "rgb_to_hsl_converter_assert.svh"

module rgb_to_hsl_converter #(
   parameter int HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEFAULT,
   parameter int LEVEL_BITS = rhc_pkg::LEVEL_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [rhc_pkg::CH_W-1:0]   req_red,
   input  logic [rhc_pkg::CH_W-1:0]   req_green,
   input  logic [rhc_pkg::CH_W-1:0]   req_blue,
   output logic                       rsp_valid,
   output logic [rhc_pkg::OUT_W-1:0]  rsp_hue,
   output logic [rhc_pkg::OUT_W-1:0]  rsp_saturation,
   output logic [rhc_pkg::OUT_W-1:0]  rsp_lightness
);
   import rhc_pkg::*;

   // Quotient width that holds both full hue (360 degrees) and full saturation.
   localparam int HUE_MAX = (6 * DEGREES_PER_SECTOR) << HUE_FRAC_BITS;
   localparam int HUE_QW = $clog2(HUE_MAX + 1);
   localparam int LVL_QW = LEVEL_BITS + 1;
   localparam int QW = (HUE_QW > LVL_QW) ? HUE_QW : LVL_QW;
   localparam int NW = QW + CH_W;
   localparam int LATENCY = QW + 4;
   localparam int SUM_W = CH_W + 1;
   localparam int MUL_W = SECTOR_W + 6;
   localparam logic [OUT_W-1:0] LIGHT_WHITE = OUT_W'(1 << LEVEL_BITS);

   // Lightness is sum * 2^LEVEL_BITS / 510, taken as sum times a rounded-up reciprocal.
   // The reciprocal is off by less than 510 / 2^18 per unit of sum, so for sums up to
   // 510 the error stays below one step of the quotient and truncation is exact.
   localparam int LIG_SHIFT = 18;
   localparam int LIG_MW = LEVEL_BITS + 10;
   localparam int LIG_PW = SUM_W + LIG_MW;
   localparam longint unsigned LIG_RECIP_FULL =
      ((64'd1 << (LEVEL_BITS + LIG_SHIFT)) + 64'(LIGHT_DEN - 1)) / 64'(LIGHT_DEN);
   localparam logic [LIG_MW-1:0] LIG_RECIP = LIG_MW'(LIG_RECIP_FULL);

   logic req_fire;
   logic [LATENCY-1:0] pipe_vld_ff;
   logic [LATENCY-1:0] pipe_vld_in;

   assign busy = reset;
   assign req_fire = start && !busy;

   // Input register.
   logic [CH_W-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         red_ff <= req_red;
         green_ff <= req_green;
         blue_ff <= req_blue;
      end
   end

   // Stage A: extremes, sum, spread, sector position and saturation divisor.
   logic [CH_W-1:0]     mx, mn;
   logic [SUM_W-1:0]    sum_in;
   logic [CH_W-1:0]     spread_in;
   logic [SECTOR_W-1:0] sector_in;
   logic [CH_W-1:0]     sat_den_in;
   logic [SUM_W-1:0]    sum_ff;
   logic [CH_W-1:0]     spread_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic [CH_W-1:0]     sat_den_ff;

   always_comb begin
      logic [SECTOR_W-1:0] d_w;
      mx = (red_ff > green_ff) ? red_ff : green_ff;
      mx = (mx > blue_ff) ? mx : blue_ff;
      mn = (red_ff < green_ff) ? red_ff : green_ff;
      mn = (mn < blue_ff) ? mn : blue_ff;
      sum_in = SUM_W'(mx) + SUM_W'(mn);
      spread_in = mx - mn;
      d_w = SECTOR_W'(spread_in);
      // Red is tested first, then green; a red with both others at the minimum
      // lands on sector value six, which is the full 360 degrees.
      if (red_ff == mx) begin
         if (green_ff == mn) begin
            sector_in = SECTOR_W'(5) * d_w + SECTOR_W'(mx - blue_ff);
         end else begin
            sector_in = SECTOR_W'(green_ff - mn);
         end
      end else if (green_ff == mx) begin
         if (blue_ff == mn) begin
            sector_in = d_w + SECTOR_W'(mx - red_ff);
         end else begin
            sector_in = SECTOR_W'(3) * d_w - SECTOR_W'(mx - blue_ff);
         end
      end else begin
         if (red_ff == mn) begin
            sector_in = SECTOR_W'(3) * d_w + SECTOR_W'(mx - green_ff);
         end else begin
            sector_in = SECTOR_W'(5) * d_w - SECTOR_W'(mx - red_ff);
         end
      end
      if (sum_in <= SUM_W'(255)) begin
         sat_den_in = sum_in[CH_W-1:0];
      end else begin
         sat_den_in = CH_W'(SUM_W'(LIGHT_DEN) - sum_in);
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      spread_ff <= spread_in;
      sector_ff <= sector_in;
      sat_den_ff <= sat_den_in;
   end

   // Stage B: numerators and divisors. Grey and black pixels divide zero by one.
   // Lightness is finished here by the reciprocal multiply.
   logic [NW-1:0]     hue_num_in, sat_num_in, hue_num_ff, sat_num_ff;
   logic [CH_W-1:0]   hue_den_in, sat_den2_in, hue_den_ff, sat_den2_ff;
   logic [LVL_QW-1:0] lig_q_in, lig_q_ff;
   logic              grey;

   always_comb begin
      logic [MUL_W-1:0] scaled;
      logic [LIG_PW-1:0] lig_prod;
      grey = (spread_ff == '0);
      scaled = MUL_W'(sector_ff) * MUL_W'(DEGREES_PER_SECTOR);
      lig_prod = LIG_PW'(sum_ff) * LIG_PW'(LIG_RECIP);
      lig_q_in = lig_prod[LIG_SHIFT +: LVL_QW];
      if (grey) begin
         hue_num_in = '0;
         sat_num_in = '0;
         hue_den_in = CH_W'(1);
         sat_den2_in = CH_W'(1);
      end else begin
         hue_num_in = NW'(scaled) << HUE_FRAC_BITS;
         sat_num_in = NW'(spread_ff) << LEVEL_BITS;
         hue_den_in = spread_ff;
         sat_den2_in = sat_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      hue_num_ff <= hue_num_in;
      sat_num_ff <= sat_num_in;
      lig_q_ff <= lig_q_in;
      hue_den_ff <= hue_den_in;
      sat_den2_ff <= sat_den2_in;
   end

   // Dividers, both of the same depth so the results stay aligned.
   logic [QW-1:0] hue_quo, sat_quo;

   rhc_div #(.QW(QW), .DW(CH_W)) u_hue_div (
      .clock (clock),
      .num   (hue_num_ff),
      .den   (hue_den_ff),
      .quo   (hue_quo)
   );

   rhc_div #(.QW(QW), .DW(CH_W)) u_sat_div (
      .clock (clock),
      .num   (sat_num_ff),
      .den   (sat_den2_ff),
      .quo   (sat_quo)
   );

   // Lightness waits in a delay line as deep as the dividers.
   logic [LVL_QW-1:0] lig_dly_ff [QW];

   always_ff @(posedge clock) begin
      lig_dly_ff[0] <= lig_q_ff;
      for (int k = 1; k < QW; k++) begin
         lig_dly_ff[k] <= lig_dly_ff[k-1];
      end
   end

   // Output register; results wrap to the port width.
   logic [OUT_W-1:0] hue_ff, sat_ff, lig_ff;

   always_ff @(posedge clock) begin
      hue_ff <= OUT_W'(hue_quo);
      sat_ff <= OUT_W'(sat_quo);
      lig_ff <= OUT_W'(lig_dly_ff[QW-1]);
   end

   // Valid bits travel alongside the data, one per stage.
   assign pipe_vld_in = {pipe_vld_ff[LATENCY-2:0], req_fire};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_vld_ff <= '0;
      end else begin
         pipe_vld_ff <= pipe_vld_in;
      end
   end

   assign rsp_valid = pipe_vld_ff[LATENCY-1];
   assign rsp_hue = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness = lig_ff;

   // Terms used by the checks below.
   logic px_black, px_white, out_zero, out_white, num_zero;

   assign px_black = req_fire && req_red == '0 && req_green == '0 && req_blue == '0;
   assign px_white = req_fire && req_red == '1 && req_green == '1 && req_blue == '1;
   assign out_zero = rsp_hue == '0 && rsp_saturation == '0 && rsp_lightness == '0;
   assign out_white = rsp_lightness == LIGHT_WHITE;
   assign num_zero = hue_num_ff == '0 && sat_num_ff == '0;

   // A strobe always belongs to a beat taken earlier and carried down the valid chain.
   `RHC_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(req_fire, LATENCY))
   // Black pixels come out as all zeros.
   `RHC_ASSERT_IMPLY(a_black_zero, clock, reset, rsp_valid && $past(px_black, LATENCY), out_zero)
   // White pixels come out at full lightness.
   `RHC_ASSERT_IMPLY(a_white_full, clock, reset, rsp_valid && $past(px_white, LATENCY), out_white)
   // A grey pixel in the sector stage feeds zero numerators to hue and saturation.
   `RHC_ASSERT_NEXT(a_grey_zero_num, clock, reset, pipe_vld_ff[1] && grey, num_zero)
endmodule
